// ===== rtl/wfca_pkg.sv =====
// shared types and constants of the windowed frame cache accounting block
package wfca_pkg;

  localparam int IDX_W      = 10;
  localparam int COUNT_W    = 11;
  localparam int BYTES_W    = 32;
  localparam int TOTAL_W    = 42;
  localparam int RADIUS_W   = 11;
  localparam int EPOCH_W    = 8;
  localparam int FRAME_SPAN = 1 << IDX_W;

  localparam int MAX_FRAMES_DEF = 1024;

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [0:0] REG_WINDOW_RADIUS = 1'b0;
  localparam logic [0:0] REG_WRAP_AROUND   = 1'b1;

  localparam logic [RADIUS_W-1:0] RADIUS_RESET = RADIUS_W'(2);

  localparam logic [1:0] FUNC_RECORD = 2'd0;
  localparam logic [1:0] FUNC_VISIT  = 2'd1;
  localparam logic [1:0] FUNC_CLEAR  = 2'd2;

  localparam logic [EPOCH_W-1:0] EPOCH_LAST = '1;

  typedef struct packed {
    logic [1:0]         func;
    logic [IDX_W-1:0]   frame_index;
    logic               has_pixels;
    logic [BYTES_W-1:0] byte_count;
    logic               is_protected;
    logic [IDX_W-1:0]   current_index;
    logic [COUNT_W-1:0] frame_count;
  } item_t;

  typedef struct packed {
    logic               evict;
    logic [TOTAL_W-1:0] total_bytes;
    logic [COUNT_W-1:0] cached_frames;
  } result_t;

  typedef struct packed {
    logic [RADIUS_W-1:0] window_radius;
    logic                wrap_around;
  } cfg_t;

  // one table entry: valid only while its epoch matches the current one
  typedef struct packed {
    logic               valid;
    logic [EPOCH_W-1:0] epoch;
    logic [BYTES_W-1:0] bytes;
  } entry_t;

endpackage

// ===== rtl/wfca_table_ram.sv =====
// frame table memory: one write port, one registered read port
module wfca_table_ram #(
  parameter int DEPTH = wfca_pkg::MAX_FRAMES_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  wfca_pkg::entry_t wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output wfca_pkg::entry_t rdata
);

  wfca_pkg::entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/wfca_cfg.sv =====
// configuration registers behind the apb port
module wfca_cfg (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [wfca_pkg::CFG_ADDR_W-1:0]     paddr,
  input  logic [wfca_pkg::CFG_DATA_W-1:0]     pwdata,
  output logic [wfca_pkg::CFG_DATA_W-1:0]     prdata,
  output logic                                pready,
  output wfca_pkg::cfg_t                      cfg
);

  logic       wr;
  logic [0:0] sel;

  assign pready = 1'b1;
  assign sel    = paddr[2:2];
  assign wr     = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.window_radius <= wfca_pkg::RADIUS_RESET;
      cfg.wrap_around   <= 1'b0;
    end else if (wr) begin
      case (sel)
        wfca_pkg::REG_WINDOW_RADIUS: cfg.window_radius <= pwdata[wfca_pkg::RADIUS_W-1:0];
        wfca_pkg::REG_WRAP_AROUND:   cfg.wrap_around   <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (sel)
      wfca_pkg::REG_WINDOW_RADIUS: prdata[wfca_pkg::RADIUS_W-1:0] = cfg.window_radius;
      wfca_pkg::REG_WRAP_AROUND:   prdata[0] = cfg.wrap_around;
      default: prdata = '0;
    endcase
  end

endmodule

// ===== rtl/wfca_window.sv =====
// distance check of a frame against the window around the current frame
module wfca_window (
  input  logic [wfca_pkg::IDX_W-1:0]   frame_index,
  input  logic [wfca_pkg::IDX_W-1:0]   current_index,
  input  logic [wfca_pkg::COUNT_W-1:0] frame_count,
  input  wfca_pkg::cfg_t               cfg,
  output logic                         in_window
);

  logic [wfca_pkg::IDX_W-1:0]   direct;
  logic [wfca_pkg::COUNT_W-1:0] direct_w;
  logic [wfca_pkg::COUNT_W-1:0] other;
  logic [wfca_pkg::COUNT_W-1:0] gap;
  logic                         use_wrap;

  always_comb begin
    direct   = (frame_index >= current_index) ? frame_index - current_index
                                              : current_index - frame_index;
    direct_w = {1'b0, direct};
    other    = frame_count - direct_w;
    use_wrap = cfg.wrap_around && (frame_count > wfca_pkg::COUNT_W'(1))
               && (direct_w < frame_count);
    gap       = (use_wrap && (other < direct_w)) ? other : direct_w;
    in_window = (gap <= cfg.window_radius);
  end

endmodule

// ===== rtl/windowed_frame_cache_accounting.sv =====
// windowed frame cache accounting: frame table, byte total and cached frame count
//
// items come in on item / item_valid / item_stall and each gives exactly one
// result on result / result_valid / result_stall. a transfer happens at a clock
// edge with valid high and stall low.
// the table read and the item are registered in stage 1 when the item transfers,
// and the update lands in the output register when stage 1 moves on; a stalled
// result holds stage 1 in place.
// throughput: one item per cycle outside sweeps and last-epoch clears, set by the
// single read-modify-write pass over the table memory; back-to-back items on one
// frame use the forwarded write. the output register lets the next item in while a
// result waits; a stalled result holds and the pipeline backs up into item_stall.
// clear (and a visit with a zero frame count) is a flash clear by epoch. every
// 256th clear and every reset start a sweep over all table entries (MAX_FRAMES,
// at most 1024) that writes every entry invalid; item_stall is high during the
// sweep. configuration writes on the apb port are taken at any time.
// rst is synchronous and active high; it zeroes the total and the count and
// sets window_radius to 2 and wrap_around to 0.
module windowed_frame_cache_accounting #(
  parameter int MAX_FRAMES = wfca_pkg::MAX_FRAMES_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  wfca_pkg::item_t                 item,
  input  logic                            item_valid,
  output logic                            item_stall,
  output wfca_pkg::result_t               result,
  output logic                            result_valid,
  input  logic                            result_stall,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [wfca_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [wfca_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [wfca_pkg::CFG_DATA_W-1:0] prdata,
  output logic                            pready
);

  localparam int DEPTH = (MAX_FRAMES < wfca_pkg::FRAME_SPAN) ? MAX_FRAMES
                                                              : wfca_pkg::FRAME_SPAN;
  localparam int AW = $clog2(DEPTH);
  localparam logic [wfca_pkg::COUNT_W-1:0] DEPTH_L = wfca_pkg::COUNT_W'(DEPTH);
  localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

  wfca_pkg::cfg_t cfg;

  // config
  wfca_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  logic in_within;

  wfca_window u_window (
    .frame_index   (item.frame_index),
    .current_index (item.current_index),
    .frame_count   (item.frame_count),
    .cfg           (cfg),
    .in_window     (in_within)
  );

  // table stage registers
  logic                         s1_valid;
  wfca_pkg::item_t              s1_item;
  logic [AW-1:0]                s1_addr;
  logic                         s1_in_range;
  logic                         s1_within;
  logic                         s1_fwd;
  wfca_pkg::entry_t             s1_fwd_data;

  logic [wfca_pkg::EPOCH_W-1:0] epoch;
  logic                         sweeping;
  logic [AW-1:0]                sweep_addr;
  logic [wfca_pkg::TOTAL_W-1:0] byte_total;
  logic [wfca_pkg::COUNT_W-1:0] entry_count;

  logic                         accept;
  logic                         s1_go;
  logic                         wrap_hold;
  logic [AW-1:0]                in_addr;

  wfca_pkg::entry_t             rdata;
  wfca_pkg::entry_t             ent;
  logic                         ent_valid;
  logic                         is_clear;
  logic                         visit_ok;
  logic                         do_store;
  logic                         do_drop;
  logic                         evict;
  logic                         same_bytes;
  logic [wfca_pkg::BYTES_W-1:0] prev;

  logic                         item_we;
  wfca_pkg::entry_t             item_wdata;
  logic [wfca_pkg::TOTAL_W-1:0] byte_total_next;
  logic [wfca_pkg::COUNT_W-1:0] entry_count_next;

  logic                         mem_we;
  logic [AW-1:0]                mem_waddr;
  wfca_pkg::entry_t             mem_wdata;

  assign in_addr   = item.frame_index[AW-1:0];
  assign s1_go     = s1_valid && (!result_valid || !result_stall);
  assign wrap_hold = s1_valid && is_clear && (epoch == wfca_pkg::EPOCH_LAST);
  assign item_stall = sweeping || wrap_hold || (s1_valid && !s1_go);
  assign accept    = item_valid && !item_stall;

  always_comb begin
    ent       = s1_fwd ? s1_fwd_data : rdata;
    ent_valid = ent.valid && (ent.epoch == epoch);
    is_clear  = (s1_item.func == wfca_pkg::FUNC_CLEAR)
                || ((s1_item.func == wfca_pkg::FUNC_VISIT) && (s1_item.frame_count == '0));
    visit_ok  = (s1_item.func == wfca_pkg::FUNC_VISIT) && (s1_item.frame_count != '0)
                && s1_in_range && !s1_item.is_protected;
    do_store  = s1_in_range && s1_item.has_pixels
                && ((s1_item.func == wfca_pkg::FUNC_RECORD) || (visit_ok && s1_within));
    do_drop   = visit_ok && (!s1_item.has_pixels || !s1_within);
    evict     = visit_ok && s1_item.has_pixels && !s1_within;
    same_bytes = ent_valid && (ent.bytes == s1_item.byte_count);
    prev      = ent_valid ? ent.bytes : '0;

    item_we          = 1'b0;
    item_wdata.valid = 1'b1;
    item_wdata.epoch = epoch;
    item_wdata.bytes = s1_item.byte_count;
    byte_total_next  = byte_total;
    entry_count_next = entry_count;

    if (is_clear) begin
      byte_total_next  = '0;
      entry_count_next = '0;
    end else if (do_store && !same_bytes) begin
      item_we         = 1'b1;
      byte_total_next = byte_total + wfca_pkg::TOTAL_W'(s1_item.byte_count)
                        - wfca_pkg::TOTAL_W'(prev);
      if (!ent_valid) begin
        entry_count_next = entry_count + wfca_pkg::COUNT_W'(1);
      end
    end else if (do_drop && ent_valid) begin
      item_we          = 1'b1;
      item_wdata.valid = 1'b0;
      item_wdata.bytes = ent.bytes;
      byte_total_next  = byte_total - wfca_pkg::TOTAL_W'(ent.bytes);
      entry_count_next = entry_count - wfca_pkg::COUNT_W'(1);
    end
  end

  always_comb begin
    if (sweeping) begin
      mem_we    = 1'b1;
      mem_waddr = sweep_addr;
      mem_wdata = '0;
    end else begin
      mem_we    = s1_go && item_we;
      mem_waddr = s1_addr;
      mem_wdata = item_wdata;
    end
  end

  wfca_table_ram #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (accept),
    .raddr (in_addr),
    .rdata (rdata)
  );

  // stage 1 capture, with forwarding of the write at the same edge
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_item     <= item;
      s1_addr     <= in_addr;
      s1_in_range <= ({1'b0, item.frame_index} < DEPTH_L);
      s1_within   <= in_within;
      s1_fwd      <= s1_go && item_we && (s1_addr == in_addr);
      s1_fwd_data <= item_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid     <= 1'b0;
      result_valid <= 1'b0;
      epoch        <= '0;
      sweeping     <= 1'b1;
      sweep_addr   <= '0;
      byte_total   <= '0;
      entry_count  <= '0;
    end else begin
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (s1_go) begin
        s1_valid <= 1'b0;
      end

      if (s1_go) begin
        result_valid         <= 1'b1;
        result.evict         <= evict;
        result.total_bytes   <= byte_total_next;
        result.cached_frames <= entry_count_next;
        byte_total           <= byte_total_next;
        entry_count          <= entry_count_next;
        if (is_clear) begin
          if (epoch == wfca_pkg::EPOCH_LAST) begin
            epoch      <= '0;
            sweeping   <= 1'b1;
            sweep_addr <= '0;
          end else begin
            epoch <= epoch + wfca_pkg::EPOCH_W'(1);
          end
        end
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end

      if (sweeping) begin
        sweep_addr <= sweep_addr + AW'(1);
        if (sweep_addr == LAST_ADDR) begin
          sweeping <= 1'b0;
        end
      end
    end
  end

endmodule
